// ===== hdl/mkdh_pkg.sv =====
// Shared types, constants and helpers for the multi-key debounce block.
package mkdh_pkg;

  // Field and counter widths
  localparam int KEY_FIELD_W = 8;
  localparam int CNT_W       = 16;
  localparam int TRIG_W      = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // Default key count
  localparam int NUM_KEYS_DEF = 8;

  // Register reset values
  localparam logic [CNT_W-1:0] PRESS_FILTER_RST   = CNT_W'(100);
  localparam logic [CNT_W-1:0] RELEASE_FILTER_RST = CNT_W'(100);
  localparam logic [CNT_W-1:0] HOLD_FIRST_RST     = CNT_W'(2000);
  localparam logic [CNT_W-1:0] HOLD_REPEAT_RST    = CNT_W'(1000);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_FILTER   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_FILTER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_FIRST     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_REPEAT    = 3'd5;

  // Trigger mask bits
  localparam int TRIG_PRESS   = 0;
  localparam int TRIG_RELEASE = 1;
  localparam int TRIG_HOLD    = 2;

  // Per-key state word held in the state memory
  typedef struct packed {
    logic             level;
    logic [CNT_W-1:0] press_cnt;
    logic [CNT_W-1:0] release_cnt;
    logic [CNT_W-1:0] first_cnt;
    logic [CNT_W-1:0] repeat_cnt;
  } key_state_t;

  // Shared thresholds and trigger mask
  typedef struct packed {
    logic [TRIG_W-1:0] trigger;
    logic [CNT_W-1:0]  press_ticks;
    logic [CNT_W-1:0]  release_ticks;
    logic [CNT_W-1:0]  first_ticks;
    logic [CNT_W-1:0]  repeat_ticks;
  } key_cfg_t;

  // Events raised by one key in one tick
  typedef struct packed {
    logic press;
    logic release_ev;
    logic hold;
  } key_ev_t;

  // Saturating increment of a counter
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    return r;
  endfunction

endpackage

// ===== hdl/mkdh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mkdh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/mkdh_update.sv =====
// Per-key debounce and hold-repeat update of one state word.
module mkdh_update (
  input  mkdh_pkg::key_state_t cur,
  input  logic                 level,
  input  mkdh_pkg::key_cfg_t   cfg,
  output mkdh_pkg::key_state_t nxt,
  output mkdh_pkg::key_ev_t    ev
);

  logic [mkdh_pkg::CNT_W-1:0] press_inc;
  logic [mkdh_pkg::CNT_W-1:0] release_inc;
  logic [mkdh_pkg::CNT_W-1:0] first_inc;
  logic [mkdh_pkg::CNT_W-1:0] repeat_inc;

  assign press_inc   = mkdh_pkg::sat_inc(cur.press_cnt);
  assign release_inc = mkdh_pkg::sat_inc(cur.release_cnt);
  assign first_inc   = mkdh_pkg::sat_inc(cur.first_cnt);
  assign repeat_inc  = mkdh_pkg::sat_inc(cur.repeat_cnt);

  // Filter a level change, or run the hold counters on a steady level
  always_comb begin
    nxt = cur;
    ev  = '0;
    if (level != cur.level) begin
      nxt.first_cnt  = '0;
      nxt.repeat_cnt = '0;
      if (level) begin
        nxt.press_cnt = press_inc;
        if (press_inc >= cfg.press_ticks) begin
          ev.press      = cfg.trigger[mkdh_pkg::TRIG_PRESS];
          nxt.level     = 1'b1;
          nxt.press_cnt = '0;
        end
      end else begin
        nxt.release_cnt = release_inc;
        if (release_inc >= cfg.release_ticks) begin
          ev.release_ev   = cfg.trigger[mkdh_pkg::TRIG_RELEASE];
          nxt.level       = 1'b0;
          nxt.release_cnt = '0;
        end
      end
    end else begin
      nxt.press_cnt   = '0;
      nxt.release_cnt = '0;
      if (level) begin
        nxt.first_cnt  = first_inc;
        nxt.repeat_cnt = repeat_inc;
        if (first_inc >= cfg.first_ticks && repeat_inc >= cfg.repeat_ticks) begin
          ev.hold        = cfg.trigger[mkdh_pkg::TRIG_HOLD];
          nxt.repeat_cnt = '0;
        end
      end
    end
  end

endmodule

// ===== hdl/multi_key_debounce_with_hold_repeat.sv =====
// Top level: key debounce with hold auto-repeat over a per-key state memory.
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+------------------------------------
//   in      | input     | in_valid / in_stall   | key_levels
//   out     | output    | out_valid / out_stall | press_events, release_events,
//           |           |                       | hold_events
//   cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// Each item sweeps min(NUM_KEYS, 8) keys: the sweep reads one key's state
// word a cycle from the single-read-port state memory, updates it and writes it back.
// A new item waits until the last key of the previous item has left its update stage, so no
// read overlaps a pending write to the same entry.
// Reset (rst, synchronous) clears the control registers and per-key valid bits, and loads
// the configuration defaults; a key whose valid bit is clear reads as released with all
// counters zero. A finished result waits in a result stage while the output register is
// stalled; the input stalls until that stage empties.
module multi_key_debounce_with_hold_repeat #(
  parameter int NUM_KEYS = mkdh_pkg::NUM_KEYS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mkdh_pkg::KEY_FIELD_W-1:0]    key_levels,
  // Output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mkdh_pkg::KEY_FIELD_W-1:0]    press_events,
  output logic [mkdh_pkg::KEY_FIELD_W-1:0]    release_events,
  output logic [mkdh_pkg::KEY_FIELD_W-1:0]    hold_events,
  // Configuration port
  input  logic                                cfg_we,
  input  logic [mkdh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mkdh_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Keys beyond the level field never change, so only those inside it are swept
  localparam int ACTIVE   = (NUM_KEYS < mkdh_pkg::KEY_FIELD_W) ? NUM_KEYS
                                                               : mkdh_pkg::KEY_FIELD_W;
  localparam int KW       = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;
  localparam int VLD_N    = 1 << KW;
  localparam int STATE_W  = $bits(mkdh_pkg::key_state_t);
  localparam logic [KW-1:0] LAST_KEY = KW'(ACTIVE - 1);

  // Configuration registers
  logic [mkdh_pkg::KEY_FIELD_W-1:0] key_enable_mask;
  mkdh_pkg::key_cfg_t               cfg;

  // Sweep control
  logic                             sweeping;
  logic [KW-1:0]                    key_idx;
  logic [mkdh_pkg::KEY_FIELD_W-1:0] levels;

  // Update stage
  logic                             s1_valid;
  logic                             s1_last;
  logic [KW-1:0]                    s1_key;
  logic                             s1_level;
  logic                             s1_en;
  logic                             s1_written;

  logic [VLD_N-1:0]                 written;
  logic [STATE_W-1:0]               ram_q;
  mkdh_pkg::key_state_t             cur;
  mkdh_pkg::key_state_t             nxt;
  mkdh_pkg::key_ev_t                ev;
  logic                             wr_en;

  // Event accumulation and result stage
  logic [mkdh_pkg::KEY_FIELD_W-1:0] acc_press;
  logic [mkdh_pkg::KEY_FIELD_W-1:0] acc_release;
  logic [mkdh_pkg::KEY_FIELD_W-1:0] acc_hold;
  logic [mkdh_pkg::KEY_FIELD_W-1:0] key_bit;
  logic [mkdh_pkg::KEY_FIELD_W-1:0] fin_press;
  logic [mkdh_pkg::KEY_FIELD_W-1:0] fin_release;
  logic [mkdh_pkg::KEY_FIELD_W-1:0] fin_hold;
  logic                             res_full;
  logic [mkdh_pkg::KEY_FIELD_W-1:0] res_press;
  logic [mkdh_pkg::KEY_FIELD_W-1:0] res_release;
  logic [mkdh_pkg::KEY_FIELD_W-1:0] res_hold;

  logic                             in_take;
  logic                             res_move;
  logic                             out_free;

  // Handshake decisions
  assign in_stall = sweeping || (s1_valid && s1_last) || (res_full && !res_move);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign res_move = res_full && out_free;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_enable_mask   <= '0;
      cfg.trigger       <= '0;
      cfg.press_ticks   <= mkdh_pkg::PRESS_FILTER_RST;
      cfg.release_ticks <= mkdh_pkg::RELEASE_FILTER_RST;
      cfg.first_ticks   <= mkdh_pkg::HOLD_FIRST_RST;
      cfg.repeat_ticks  <= mkdh_pkg::HOLD_REPEAT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mkdh_pkg::REG_KEY_ENABLE:     key_enable_mask   <= cfg_data[mkdh_pkg::KEY_FIELD_W-1:0];
        mkdh_pkg::REG_TRIGGER:        cfg.trigger       <= cfg_data[mkdh_pkg::TRIG_W-1:0];
        mkdh_pkg::REG_PRESS_FILTER:   cfg.press_ticks   <= cfg_data[mkdh_pkg::CNT_W-1:0];
        mkdh_pkg::REG_RELEASE_FILTER: cfg.release_ticks <= cfg_data[mkdh_pkg::CNT_W-1:0];
        mkdh_pkg::REG_HOLD_FIRST:     cfg.first_ticks   <= cfg_data[mkdh_pkg::CNT_W-1:0];
        mkdh_pkg::REG_HOLD_REPEAT:    cfg.repeat_ticks  <= cfg_data[mkdh_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the key sweep, one memory read a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      sweeping <= 1'b0;
      key_idx  <= '0;
    end else if (in_take) begin
      sweeping <= 1'b1;
      key_idx  <= '0;
    end else if (sweeping) begin
      if (key_idx == LAST_KEY) begin
        sweeping <= 1'b0;
      end
      key_idx <= key_idx + KW'(1);
    end
  end

  // Capture the sampled levels of the accepted item
  always_ff @(posedge clk) begin
    if (in_take) begin
      levels <= key_levels;
    end
  end

  // Stage the swept key alongside its memory read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_last  <= 1'b0;
    end else begin
      s1_valid <= sweeping;
      s1_last  <= sweeping && (key_idx == LAST_KEY);
    end
  end

  always_ff @(posedge clk) begin
    s1_key     <= key_idx;
    s1_level   <= levels[key_idx];
    s1_en      <= key_enable_mask[key_idx];
    s1_written <= written[key_idx];
  end

  // Per-key state memory
  mkdh_ram #(
    .WIDTH (STATE_W),
    .DEPTH (ACTIVE)
  ) u_state_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_key),
    .wdata (nxt),
    .re    (sweeping),
    .raddr (key_idx),
    .rdata (ram_q)
  );

  // A never-written entry reads as the reset state
  assign cur = s1_written ? mkdh_pkg::key_state_t'(ram_q) : '0;

  mkdh_update u_update (
    .cur   (cur),
    .level (s1_level),
    .cfg   (cfg),
    .nxt   (nxt),
    .ev    (ev)
  );

  // Write back only enabled keys; a disabled key stays frozen
  assign wr_en = s1_valid && s1_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[s1_key] <= 1'b1;
    end
  end

  // Merge this key's events into the item's bitmaps
  assign key_bit     = (s1_valid && s1_en) ? (mkdh_pkg::KEY_FIELD_W'(1) << s1_key) : '0;
  assign fin_press   = acc_press   | (ev.press      ? key_bit : '0);
  assign fin_release = acc_release | (ev.release_ev ? key_bit : '0);
  assign fin_hold    = acc_hold    | (ev.hold       ? key_bit : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_press   <= '0;
      acc_release <= '0;
      acc_hold    <= '0;
    end else if (s1_valid) begin
      if (s1_last) begin
        acc_press   <= '0;
        acc_release <= '0;
        acc_hold    <= '0;
      end else begin
        acc_press   <= fin_press;
        acc_release <= fin_release;
        acc_hold    <= fin_hold;
      end
    end
  end

  // Hold the finished item until the output register frees
  always_ff @(posedge clk) begin
    if (rst) begin
      res_full <= 1'b0;
    end else if (s1_valid && s1_last) begin
      res_full <= 1'b1;
    end else if (res_move) begin
      res_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_last) begin
      res_press   <= fin_press;
      res_release <= fin_release;
      res_hold    <= fin_hold;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_move) begin
      press_events   <= res_press;
      release_events <= res_release;
      hold_events    <= res_hold;
    end
  end

endmodule

// ===== hdl/mkdh_checker.sv =====
// Port-level checks for the multi-key debounce block, bound to the top level.
module mkdh_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic [mkdh_pkg::KEY_FIELD_W-1:0] key_levels,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [mkdh_pkg::KEY_FIELD_W-1:0] press_events,
  input logic [mkdh_pkg::KEY_FIELD_W-1:0] release_events,
  input logic [mkdh_pkg::KEY_FIELD_W-1:0] hold_events
);

  // No result is shown right after reset
  a_reset_quiet: assert property (@(posedge clk) ($past(rst) && !rst) |-> !out_valid)
    else $error("result shown right after reset");

  // An accepted item keeps the block busy for its sweep
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again before the sweep ran");

  // A stalled input item holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_stall) |=> (in_valid && $stable(key_levels)))
    else $error("stalled input item changed");

  // A key raises at most one kind of event per tick
  a_events_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((press_events & release_events) == '0 &&
                   (press_events & hold_events) == '0 &&
                   (release_events & hold_events) == '0))
    else $error("one key raised two kinds of event in a tick");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(press_events) &&
                                  $stable(release_events) && $stable(hold_events)))
    else $error("stalled result changed");

endmodule

bind multi_key_debounce_with_hold_repeat mkdh_checker u_mkdh_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .key_levels     (key_levels),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .press_events   (press_events),
  .release_events (release_events),
  .hold_events    (hold_events)
);

// ===== dv/testbench.sv =====
// Self-checking testbench for the multi-key debounce block with hold repeat.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mkdh_pkg::*;

  localparam int KEYS = NUM_KEYS_DEF;
  localparam int SETTLE_CYCLES = 12;
  localparam int MAX_REPORTS = 10;

  // Indexes past the register list; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef logic [KEY_FIELD_W-1:0] key_vec_t;
  typedef logic [CNT_W-1:0] count_t;

  typedef struct packed {
    key_vec_t press_ev;
    key_vec_t rel_ev;
    key_vec_t hold_ev;
  } tick_events_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  key_vec_t              key_levels = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  key_vec_t              press_events;
  key_vec_t              release_events;
  key_vec_t              hold_events;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow copy of the registers
  key_vec_t          scan_mask;
  logic [TRIG_W-1:0] event_allow;
  count_t            press_need;
  count_t            release_need;
  count_t            first_need;
  count_t            repeat_need;

  // Shadow copy of the per-key debounce state
  logic   key_down [KEYS];
  count_t press_run [KEYS];
  count_t release_run [KEYS];
  count_t first_run [KEYS];
  count_t repeat_run [KEYS];

  key_vec_t     levels_pending[$];
  tick_events_t events_due[$];
  tick_events_t oldest_due;
  int           mismatches = 0;
  int           idle_odds = 0;
  int           src_gap = 0;
  int           dst_gap = 0;

  multi_key_debounce_with_hold_repeat #(.NUM_KEYS(KEYS)) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .key_levels(key_levels),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .press_events(press_events),
    .release_events(release_events),
    .hold_events(hold_events),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Count up, sticking at the top value
  function automatic count_t bump(input count_t c);
    return (&c) ? c : c + 1'b1;
  endfunction

  // Advance the shadow state by one scan tick and return the events it raises
  function automatic tick_events_t debounce_tick(input key_vec_t levels);
    tick_events_t ev;
    logic lvl;
    ev = '0;
    for (int k = 0; k < KEYS; k++) begin
      if (scan_mask[k]) begin
        lvl = levels[k];
        if (lvl != key_down[k]) begin
          // level moved away from the accepted one: run the edge filter
          first_run[k] = '0;
          repeat_run[k] = '0;
          if (lvl) begin
            press_run[k] = bump(press_run[k]);
            if (press_run[k] >= press_need) begin
              ev.press_ev[k] = event_allow[TRIG_PRESS];
              key_down[k] = 1'b1;
              press_run[k] = '0;
            end
          end else begin
            release_run[k] = bump(release_run[k]);
            if (release_run[k] >= release_need) begin
              ev.rel_ev[k] = event_allow[TRIG_RELEASE];
              key_down[k] = 1'b0;
              release_run[k] = '0;
            end
          end
        end else begin
          // steady level: drop the filters, run the hold timers while down
          press_run[k] = '0;
          release_run[k] = '0;
          if (lvl) begin
            first_run[k] = bump(first_run[k]);
            repeat_run[k] = bump(repeat_run[k]);
            if (first_run[k] >= first_need && repeat_run[k] >= repeat_need) begin
              ev.hold_ev[k] = event_allow[TRIG_HOLD];
              repeat_run[k] = '0;
            end
          end
        end
      end
    end
    return ev;
  endfunction

  function automatic void note_mismatch(input string what);
    if (mismatches < MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endfunction

  // Drive one register write and mirror it in the shadow copy
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_KEY_ENABLE:     scan_mask = val[KEY_FIELD_W-1:0];
      REG_TRIGGER:        event_allow = val[TRIG_W-1:0];
      REG_PRESS_FILTER:   press_need = val;
      REG_RELEASE_FILTER: release_need = val;
      REG_HOLD_FIRST:     first_need = val;
      REG_HOLD_REPEAT:    repeat_need = val;
      default: ;
    endcase
  endtask

  // Write every register, then drop the write enable
  task automatic configure(input logic [CFG_DATA_W-1:0] en, input logic [CFG_DATA_W-1:0] trig,
                           input count_t p, input count_t r, input count_t f, input count_t rp);
    write_reg(REG_KEY_ENABLE, en);
    write_reg(REG_TRIGGER, trig);
    write_reg(REG_PRESS_FILTER, p);
    write_reg(REG_RELEASE_FILTER, r);
    write_reg(REG_HOLD_FIRST, f);
    write_reg(REG_HOLD_REPEAT, rp);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every item is taken and every result has come back
  task automatic drain();
    @(negedge clk);
    while (levels_pending.size() != 0 || in_valid || events_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic count_t pick_ticks();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return count_t'($urandom);
      default: return count_t'($urandom_range(1, 6));
    endcase
  endfunction

  // Held levels with occasional key changes and contact bounce, or plain noise
  task automatic random_phase(input int count, input bit noise_only);
    key_vec_t target;
    key_vec_t bounce;
    target = key_vec_t'($urandom);
    @(negedge clk);
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) target ^= key_vec_t'($urandom);
      bounce = ($urandom_range(0, 5) == 0) ? key_vec_t'($urandom & $urandom) : '0;
      levels_pending.push_back(noise_only ? key_vec_t'($urandom) : target ^ bounce);
    end
    drain();
  endtask

  // Driver: present pending items, with random gaps between them
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (in_valid && !in_stall) events_due.push_back(debounce_tick(key_levels));
      if (!in_valid || !in_stall) begin
        if (src_gap != 0) begin
          in_valid <= 1'b0;
          src_gap <= src_gap - 1;
        end else if (levels_pending.size() != 0) begin
          in_valid <= 1'b1;
          key_levels <= levels_pending.pop_front();
          if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
            src_gap <= $urandom_range(1, 4);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each taken result against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      dst_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (events_due.size() == 0) begin
          note_mismatch($sformatf("unexpected result press=%h release=%h hold=%h",
                                  press_events, release_events, hold_events));
        end else begin
          oldest_due = events_due.pop_front();
          if (press_events !== oldest_due.press_ev || release_events !== oldest_due.rel_ev ||
              hold_events !== oldest_due.hold_ev)
            note_mismatch($sformatf(
              "press exp %h got %h, release exp %h got %h, hold exp %h got %h",
              oldest_due.press_ev, press_events, oldest_due.rel_ev, release_events,
              oldest_due.hold_ev, hold_events));
        end
      end
      // stall in short bursts
      if (dst_gap != 0) begin
        out_stall <= 1'b1;
        dst_gap <= dst_gap - 1;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        out_stall <= 1'b1;
        dst_gap <= $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    scan_mask = '0;
    event_allow = '0;
    press_need = PRESS_FILTER_RST;
    release_need = RELEASE_FILTER_RST;
    first_need = HOLD_FIRST_RST;
    repeat_need = HOLD_REPEAT_RST;
    for (int k = 0; k < KEYS; k++) begin
      key_down[k] = 1'b0;
      press_run[k] = '0;
      release_run[k] = '0;
      first_run[k] = '0;
      repeat_run[k] = '0;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    idle_odds = 4;

    // All keys disabled after reset: no events, state frozen
    levels_pending.push_back(8'hFF);
    levels_pending.push_back(8'h00);
    levels_pending.push_back(8'h5A);
    drain();

    // Reset filter thresholds stay in force when only enable and trigger change
    write_reg(REG_KEY_ENABLE, 16'h00FF);
    write_reg(REG_TRIGGER, 16'h0007);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    repeat (102) levels_pending.push_back(8'hFF);
    repeat (102) levels_pending.push_back(8'h00);
    drain();

    // Zero thresholds, oversized write data, writes past the register list
    write_reg(REG_SPARE_LO, 16'h0000);
    write_reg(REG_SPARE_HI, 16'hFFFF);
    configure(16'hFFFF, 16'hFFFF, '0, '0, '0, '0);
    @(negedge clk);
    levels_pending.push_back(8'h00);
    levels_pending.push_back(8'hFF);
    levels_pending.push_back(8'hFF);
    levels_pending.push_back(8'h00);
    levels_pending.push_back(8'hAA);
    levels_pending.push_back(8'h55);
    levels_pending.push_back(8'h01);
    levels_pending.push_back(8'h80);
    drain();

    // Partial enable, release events masked off, bounce on release
    configure(16'h00A5, 16'h0005, 16'd2, 16'd3, 16'd3, 16'd2);
    @(negedge clk);
    repeat (6) levels_pending.push_back(8'hFF);
    levels_pending.push_back(8'h00);
    levels_pending.push_back(8'hFF);
    repeat (3) levels_pending.push_back(8'h00);
    drain();

    // Random settings, mostly small thresholds
    for (int ph = 0; ph < 10; ph++) begin
      configure(($urandom_range(0, 2) == 0) ? CFG_DATA_W'($urandom) : 16'h00FF,
                ($urandom_range(0, 1) == 0) ? CFG_DATA_W'($urandom_range(0, 7)) : 16'h0007,
                pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks());
      @(negedge clk);
      idle_odds = (ph % 3 == 2) ? 0 : $urandom_range(2, 8);
      random_phase(75, ph == 4);
    end

    // Last part runs without gaps or stalls
    @(negedge clk);
    idle_odds = 0;
    configure(16'h00FF, 16'h0007, 16'd1, 16'd2, 16'd4, 16'd3);
    random_phase(75, 1'b0);

    if (mismatches == 0 && events_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/mkdh_pkg.sv
hdl/mkdh_ram.sv
hdl/mkdh_update.sv
hdl/multi_key_debounce_with_hold_repeat.sv
hdl/mkdh_checker.sv
dv/testbench.sv
